### rtl/allocator_size_class_mapper_assert.svh
// Assertion macros for the size-class mapper.
// Included by the top level; needs nothing else.
`ifndef ALLOCATOR_SIZE_CLASS_MAPPER_ASSERT_SVH
`define ALLOCATOR_SIZE_CLASS_MAPPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ASCM_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASCM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### rtl/ascm_pkg.sv
// Shared types and constants for the size-class mapper.
// Used by the channel interfaces, the mapping logic and the top level.
`default_nettype none

package ascm_pkg;

   localparam int QUANTUM_SHIFT_DEF = 4;
   localparam int LG_GROUP_DEF      = 2;

   localparam int TYPE_W   = 2;
   localparam int AMOUNT_W = 32;
   localparam int INDEX_W  = 7;
   localparam int CFG_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int LOG_W    = 6;

   localparam logic [CFG_W-1:0] PAGE_SHIFT_MIN   = 5'd12;
   localparam logic [CFG_W-1:0] PAGE_SHIFT_MAX   = 5'd16;
   localparam logic [CFG_W-1:0] PAGE_SHIFT_RST   = 5'd13;
   localparam logic [CFG_W-1:0] CHUNK_SHIFT_MIN  = 5'd16;
   localparam logic [CFG_W-1:0] CHUNK_SHIFT_MAX  = 5'd30;
   localparam logic [CFG_W-1:0] CHUNK_SHIFT_RST  = 5'd24;

   typedef enum logic [TYPE_W-1:0] {
      REQ_SIZE_INDEX = 2'd0,
      REQ_PAGE_INDEX = 2'd1,
      REQ_NORMALIZE  = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_SHIFT  = 1'd0,
      CSR_CHUNK_SHIFT = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  class_index;
      logic [AMOUNT_W-1:0] rounded_size;
      logic                too_large;
   } result_type;

endpackage

`default_nettype wire

### rtl/ascm_req_if.sv
// Request channel of the size-class mapper: valid/ready with type and amount.
// Depends on ascm_pkg for field widths.
`default_nettype none

interface ascm_req_if;
   logic                           valid;
   logic                           ready;
   logic [ascm_pkg::TYPE_W-1:0]    req_type;
   logic [ascm_pkg::AMOUNT_W-1:0]  amount;

   modport source (output valid, output req_type, output amount, input ready);
   modport sink (input valid, input req_type, input amount, output ready);
endinterface

`default_nettype wire

### rtl/ascm_rsp_if.sv
// Response channel of the size-class mapper: valid/ready with the mapped result.
// Depends on ascm_pkg for field widths.
`default_nettype none

interface ascm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ascm_pkg::INDEX_W-1:0]   class_index;
   logic [ascm_pkg::AMOUNT_W-1:0]  rounded_size;
   logic                           too_large;

   modport source (output valid, output class_index, output rounded_size,
                   output too_large, input ready);
   modport sink (input valid, input class_index, input rounded_size,
                 input too_large, output ready);
endinterface

`default_nettype wire

### rtl/ascm_map.sv
// Closed-form size-class mapping for one request, purely combinational.
// Depends on ascm_pkg for widths, request codes and the result struct.
`default_nettype none

module ascm_map #(
   parameter int QUANTUM_SHIFT = ascm_pkg::QUANTUM_SHIFT_DEF,
   parameter int LG_GROUP      = ascm_pkg::LG_GROUP_DEF
) (
   input  wire logic [ascm_pkg::CFG_W-1:0]    page_shift,
   input  wire logic [ascm_pkg::CFG_W-1:0]    chunk_shift,
   input  wire logic [ascm_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [ascm_pkg::AMOUNT_W-1:0] amount,
   output ascm_pkg::result_type               result
);

   localparam int QG = QUANTUM_SHIFT + LG_GROUP;
   localparam int LW = ascm_pkg::LOG_W;
   localparam int AW = ascm_pkg::AMOUNT_W;
   localparam int IW = ascm_pkg::INDEX_W;
   localparam logic [IW-1:0] GROUP_MASK = IW'((1 << LG_GROUP) - 1);

   function automatic logic [LW-1:0] msb_pos(input logic [AW-1:0] v);
      logic [LW-1:0] pos;
      pos = '0;
      for (int i = 0; i < AW; i++) begin
         if (v[i]) pos = LW'(i);
      end
      return pos;
   endfunction

   logic [ascm_pkg::CFG_W-1:0] ps;
   logic [ascm_pkg::CFG_W-1:0] cs;
   logic [IW-1:0]              class_count;
   logic [AW-1:0]              dec;
   logic [LW-1:0]              x;
   logic [LW-1:0]              base;
   logic [LW-1:0]              grp_shift;
   logic [LW-1:0]              lgd;
   logic [LW-1:0]              lgd_norm;
   logic [IW-1:0]              index;
   logic [AW-1:0]              mask;
   logic [AW-1:0]              rounded;
   logic                       big;
   logic                       page_req;

   always_comb begin
      priority if (page_shift < ascm_pkg::PAGE_SHIFT_MIN) ps = ascm_pkg::PAGE_SHIFT_MIN;
      else if (page_shift > ascm_pkg::PAGE_SHIFT_MAX) ps = ascm_pkg::PAGE_SHIFT_MAX;
      else ps = page_shift;

      priority if (chunk_shift < ascm_pkg::CHUNK_SHIFT_MIN) cs = ascm_pkg::CHUNK_SHIFT_MIN;
      else if (chunk_shift > ascm_pkg::CHUNK_SHIFT_MAX) cs = ascm_pkg::CHUNK_SHIFT_MAX;
      else cs = chunk_shift;
   end

   // A page request maps like a byte request with a base shift of zero, so
   // both index paths share one leading-one detector on amount minus one.
   always_comb begin
      page_req    = (req_type == ascm_pkg::REQ_PAGE_INDEX);
      class_count = IW'((32'(cs) - 32'(QG) + 32'd1) << LG_GROUP);
      dec         = amount - AW'(1);
      x           = (dec == '0) ? '0 : msb_pos(dec) + LW'(1);
      base        = page_req ? '0 : LW'(QUANTUM_SHIFT);

      if ({1'b0, x} <= {1'b0, base} + (LW+1)'(LG_GROUP)) grp_shift = '0;
      else grp_shift = x - base - LW'(LG_GROUP);

      if ({1'b0, x} <= {1'b0, base} + (LW+1)'(LG_GROUP + 1)) lgd = base;
      else lgd = x - LW'(LG_GROUP + 1);

      index = IW'({1'b0, grp_shift} << LG_GROUP) + (IW'(dec >> lgd) & GROUP_MASK);

      if ({1'b0, x} <= (LW+1)'(QG + 1)) lgd_norm = LW'(QUANTUM_SHIFT);
      else lgd_norm = x - LW'(LG_GROUP + 1);

      mask    = (AW'(1) << lgd_norm) - AW'(1);
      rounded = (amount + mask) & ~mask;

      if (page_req) big = amount > (AW'(1) << (cs - ps));
      else big = amount > (AW'(1) << cs);
   end

   always_comb begin
      result = '0;
      if (amount != '0) begin
         unique case (req_type)
            ascm_pkg::REQ_SIZE_INDEX, ascm_pkg::REQ_PAGE_INDEX: begin
               result.too_large   = big;
               result.class_index = big ? class_count : index;
            end
            ascm_pkg::REQ_NORMALIZE: begin
               result.too_large    = big;
               result.rounded_size = big ? '0 : rounded;
            end
            default: result = '0;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/allocator_size_class_mapper.sv
// Size-class mapper for a power-of-two grouped allocator.
// The request channel carries a request type and an amount: type 0 maps a byte
// size to its class index, type 1 maps a page count to its page-class index,
// type 2 rounds a byte size up to its class size. Type 3 and a zero amount give
// an all-zero response. Sizes above the chunk set too_large.
// The response channel carries class_index, rounded_size and too_large, one
// response per request, in request order.
// The csr port writes page_shift (index 0) and chunk_shift (index 1). The user
// must make writes only while no request is in flight; this is not enforced.
// Out-of-range values are clamped. An accepted request is captured in an input
// register, mapped, and captured in an output register that drives the response.
// Throughput is one request per cycle without stalls; the mapping is a single pass.
// When the receiver stalls, the response holds and the input stage fills;
// req_bus.ready drops once both registers hold requests.
// Synchronous reset empties both stages and restores page_shift to 13 and
// chunk_shift to 24.
// Depends on ascm_pkg, ascm_req_if, ascm_rsp_if, ascm_map and the assert header.
`default_nettype none

`include "allocator_size_class_mapper_assert.svh"

module allocator_size_class_mapper #(
   parameter int QUANTUM_SHIFT = ascm_pkg::QUANTUM_SHIFT_DEF,
   parameter int LG_GROUP      = ascm_pkg::LG_GROUP_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ascm_req_if.sink                            req_bus,
   ascm_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_write_en,
   input  wire logic [ascm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ascm_pkg::CFG_W-1:0]     csr_write_data
);

   logic [ascm_pkg::CFG_W-1:0]    page_shift_ff, page_shift_in;
   logic [ascm_pkg::CFG_W-1:0]    chunk_shift_ff, chunk_shift_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [ascm_pkg::TYPE_W-1:0]   s1_type_ff, s1_type_in;
   logic [ascm_pkg::AMOUNT_W-1:0] s1_amount_ff, s1_amount_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ascm_pkg::result_type          rsp_data_ff, rsp_data_in;
   ascm_pkg::result_type          map_result;
   logic                          out_free;
   logic                          req_take;

   ascm_map #(
      .QUANTUM_SHIFT(QUANTUM_SHIFT),
      .LG_GROUP     (LG_GROUP)
   ) u_map (
      .page_shift (page_shift_ff),
      .chunk_shift(chunk_shift_ff),
      .req_type   (s1_type_ff),
      .amount     (s1_amount_ff),
      .result     (map_result)
   );

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_bus.ready;
      req_bus.ready = !s1_valid_ff || out_free;
      req_take      = req_bus.valid && req_bus.ready;

      page_shift_in  = page_shift_ff;
      chunk_shift_in = chunk_shift_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ascm_pkg::CSR_PAGE_SHIFT:  page_shift_in  = csr_write_data;
            ascm_pkg::CSR_CHUNK_SHIFT: chunk_shift_in = csr_write_data;
            default: ;
         endcase
      end

      s1_valid_in  = req_bus.ready ? req_bus.valid : s1_valid_ff;
      s1_type_in   = req_take ? req_bus.req_type : s1_type_ff;
      s1_amount_in = req_take ? req_bus.amount : s1_amount_ff;

      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (out_free && s1_valid_ff) ? map_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff  <= ascm_pkg::PAGE_SHIFT_RST;
         chunk_shift_ff <= ascm_pkg::CHUNK_SHIFT_RST;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         page_shift_ff  <= page_shift_in;
         chunk_shift_ff <= chunk_shift_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_type_ff   <= s1_type_in;
      s1_amount_ff <= s1_amount_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.class_index  = rsp_data_ff.class_index;
   assign rsp_bus.rounded_size = rsp_data_ff.rounded_size;
   assign rsp_bus.too_large    = rsp_data_ff.too_large;

   `ASCM_ASSERT_NOW(a_full_blocks_req, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_bus.ready, !req_bus.ready,
      "request accepted while both stages are full and stalled")
   `ASCM_ASSERT_NEXT(a_take_fills_s1, clock, reset,
      req_bus.valid && req_bus.ready, s1_valid_ff,
      "accepted request did not reach the input stage")
   `ASCM_ASSERT_NOW(a_big_no_round, clock, reset,
      rsp_valid_ff && rsp_data_ff.too_large, rsp_data_ff.rounded_size == '0,
      "too-large response carries a rounded size")
   `ASCM_ASSERT_NOW(a_round_no_index, clock, reset,
      rsp_valid_ff && rsp_data_ff.rounded_size != '0, rsp_data_ff.class_index == '0,
      "rounded-size response carries a class index")

endmodule

`default_nettype wire

### tb/tb_allocator_size_class_mapper.sv
// Self-checking testbench for the size-class mapper: directed corner requests, then random
// requests under several page and chunk settings, with random idling and a long receiver stall.
// Depends on ascm_pkg, ascm_req_if, ascm_rsp_if and allocator_size_class_mapper.
`default_nettype none

module tb_allocator_size_class_mapper;
   import ascm_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;
   localparam int                HOLD_CYCLES  = 60;
   localparam int                DRAIN_CYCLES = 8;

   class class_map_checker;
      localparam int QS = QUANTUM_SHIFT_DEF;
      localparam int GS = LG_GROUP_DEF;

      logic [CFG_W-1:0] page_shift_reg  = PAGE_SHIFT_RST;
      logic [CFG_W-1:0] chunk_shift_reg = CHUNK_SHIFT_RST;
      result_type       expected_maps[$];
      int               errors = 0;

      function void write_register(csr_index_type idx, logic [CFG_W-1:0] value);
         if (idx == CSR_PAGE_SHIFT) begin
            page_shift_reg = value;
         end else begin
            chunk_shift_reg = value;
         end
      endfunction

      function int unsigned page_bits();
         if (page_shift_reg < PAGE_SHIFT_MIN) return 32'(PAGE_SHIFT_MIN);
         if (page_shift_reg > PAGE_SHIFT_MAX) return 32'(PAGE_SHIFT_MAX);
         return 32'(page_shift_reg);
      endfunction

      function int unsigned chunk_bits();
         if (chunk_shift_reg < CHUNK_SHIFT_MIN) return 32'(CHUNK_SHIFT_MIN);
         if (chunk_shift_reg > CHUNK_SHIFT_MAX) return 32'(CHUNK_SHIFT_MAX);
         return 32'(chunk_shift_reg);
      endfunction

      function int unsigned floor_log2(logic [63:0] v);
         int unsigned n;
         n = 0;
         while (v > 64'd1) begin
            v = v >> 1;
            n++;
         end
         return n;
      endfunction

      function logic [63:0] class_of(logic [63:0] s, int unsigned base);
         int unsigned x;
         int unsigned grp_shift;
         int unsigned lgd;
         x = floor_log2((s << 1) - 64'd1);
         grp_shift = (x <= base + GS) ? 0 : x - (base + GS);
         lgd = (x <= base + GS + 1) ? base : x - GS - 1;
         return (64'(grp_shift) << GS) + (((s - 64'd1) >> lgd) & ((64'd1 << GS) - 64'd1));
      endfunction

      function result_type map_request(logic [TYPE_W-1:0] kind, logic [AMOUNT_W-1:0] amount);
         result_type  r;
         int unsigned ps;
         int unsigned cs;
         int unsigned x;
         int unsigned lgd;
         logic [63:0] bytes;
         logic [63:0] idx;
         logic [63:0] mask;
         logic [63:0] rounded;
         ps = page_bits();
         cs = chunk_bits();
         idx = 0;
         rounded = 0;
         r.too_large = 1'b0;
         if (amount != 0 && kind != REQ_RESERVED) begin
            bytes = (kind == REQ_PAGE_INDEX) ? (64'(amount) << ps) : 64'(amount);
            if (bytes > (64'd1 << cs)) begin
               r.too_large = 1'b1;
               if (kind != REQ_NORMALIZE) idx = 64'(cs - QS - GS + 1) << GS;
            end else if (kind == REQ_SIZE_INDEX) begin
               idx = class_of(bytes, QS);
            end else if (kind == REQ_PAGE_INDEX) begin
               idx = class_of(bytes, ps);
            end else begin
               x = floor_log2((bytes << 1) - 64'd1);
               lgd = (x <= GS + QS + 1) ? QS : x - GS - 1;
               mask = (64'd1 << lgd) - 64'd1;
               rounded = (bytes + mask) & ~mask;
            end
         end
         r.class_index  = idx[INDEX_W-1:0];
         r.rounded_size = rounded[AMOUNT_W-1:0];
         return r;
      endfunction

      function void note_request(logic [TYPE_W-1:0] kind, logic [AMOUNT_W-1:0] amount);
         expected_maps.push_back(map_request(kind, amount));
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_maps.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = expected_maps.pop_front();
         if (got.class_index !== want.class_index) begin
            $error("class_index: expected %0d, got %0d", want.class_index, got.class_index);
            errors++;
         end
         if (got.rounded_size !== want.rounded_size) begin
            $error("rounded_size: expected %0d, got %0d", want.rounded_size, got.rounded_size);
            errors++;
         end
         if (got.too_large !== want.too_large) begin
            $error("too_large: expected %0d, got %0d", want.too_large, got.too_large);
            errors++;
         end
      endfunction

      function int pending();
         return expected_maps.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   csr_index_type        csr_index;
   logic [CFG_W-1:0]     csr_write_data;
   bit                   sender_gaps  = 1'b1;
   bit                   sink_stalls  = 1'b1;
   bit                   hold_pending = 1'b0;
   class_map_checker     book;

   ascm_req_if req_bus ();
   ascm_rsp_if rsp_bus ();

   allocator_size_class_mapper u_top (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #(12 * 200000);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [AMOUNT_W-1:0] amount);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.amount   <= amount;
      do @(posedge clock); while (!req_bus.ready);
      book.note_request(kind, amount);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      book.write_register(idx, value);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (book.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [AMOUNT_W-1:0] pick_amount(logic [TYPE_W-1:0] kind);
      logic [AMOUNT_W-1:0] span;
      logic [AMOUNT_W-1:0] pow;
      span = (kind == REQ_PAGE_INDEX) ? 32'(1) << (book.chunk_bits() - book.page_bits())
                                      : 32'(1) << book.chunk_bits();
      pow = 32'(1) << $urandom_range(0, 31);
      case ($urandom_range(0, 15))
         0:           return '0;
         1, 2, 3, 4:  return $urandom_range(1, 512);
         5, 6, 7:     return pow + 32'($urandom_range(0, 2)) - 32'd1;
         8, 9, 10:    return $urandom_range(1, span);
         11, 12:      return $urandom_range(span - 4, span + 4);
         default:     return $urandom;
      endcase
   endfunction

   initial begin
      logic [TYPE_W-1:0]   kind;
      logic [CFG_W-1:0]    page_settings[7];
      logic [CFG_W-1:0]    chunk_settings[7];
      page_settings    = '{5'd12, 5'd16, 5'd0, 5'd31, 5'd14, 5'd13, 5'd15};
      chunk_settings   = '{5'd16, 5'd30, 5'd31, 5'd0, 5'd20, 5'd24, 5'd27};
      book = new();
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = '0;
      req_bus.amount   = '0;
      rsp_bus.ready    = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_PAGE_SHIFT;
      csr_write_data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(REQ_SIZE_INDEX, 32'd0);
      send_request(REQ_SIZE_INDEX, 32'd1);
      send_request(REQ_SIZE_INDEX, 32'd16);
      send_request(REQ_SIZE_INDEX, 32'd17);
      send_request(REQ_SIZE_INDEX, 32'd64);
      send_request(REQ_SIZE_INDEX, 32'd65);
      send_request(REQ_SIZE_INDEX, 32'h0100_0000);
      send_request(REQ_SIZE_INDEX, 32'h0100_0001);
      send_request(REQ_SIZE_INDEX, 32'hFFFF_FFFF);
      send_request(REQ_NORMALIZE, 32'd0);
      send_request(REQ_NORMALIZE, 32'd1);
      send_request(REQ_NORMALIZE, 32'd17);
      send_request(REQ_NORMALIZE, 32'd100);
      send_request(REQ_NORMALIZE, 32'd129);
      send_request(REQ_NORMALIZE, 32'd1000);
      send_request(REQ_NORMALIZE, 32'h0100_0000);
      send_request(REQ_NORMALIZE, 32'h0100_0001);
      send_request(REQ_PAGE_INDEX, 32'd1);
      send_request(REQ_PAGE_INDEX, 32'd5);
      send_request(REQ_PAGE_INDEX, 32'd2048);
      send_request(REQ_PAGE_INDEX, 32'd2049);
      send_request(REQ_PAGE_INDEX, 32'hFFFF_FFFF);
      send_request(REQ_RESERVED, 32'hFFFF_FFFF);
      send_request(REQ_RESERVED, 32'd5);

      for (int phase = 0; phase < 7; phase++) begin
         req_bus.valid <= 1'b0;
         wait_idle();
         write_csr(CSR_PAGE_SHIFT, page_settings[phase]);
         write_csr(CSR_CHUNK_SHIFT, chunk_settings[phase]);
         if (phase == 0) hold_pending = 1'b1;
         if (phase == 6) begin
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
         end
         for (int n = 0; n < 105; n++) begin
            kind = ($urandom_range(0, 15) == 0) ? REQ_RESERVED : TYPE_W'($urandom_range(0, 2));
            send_request(kind, pick_amount(kind));
         end
      end
      req_bus.valid <= 1'b0;

      while (book.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // The receiver owns rsp_bus.ready; the long hold lets the pipeline fill and back-pressure.
   initial begin
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_pending) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.class_index  = rsp_bus.class_index;
         got.rounded_size = rsp_bus.rounded_size;
         got.too_large    = rsp_bus.too_large;
         book.check_response(got);
      end
   end
endmodule

`default_nettype wire
